### rtl/wsfce_pkg.sv
// ----------------------------------------------------------------------------
// wsfce_pkg
// Shared types, tags, status codes and the PCM-to-float conversion.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfce_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] ENC_PCM        = 16'h0001;
  localparam logic [15:0] ENC_FLOAT      = 16'h0003;
  localparam logic [15:0] ENC_EXTENSIBLE = 16'hfffe;

  localparam logic [31:0] RATE_RESET = 32'd16000;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_NOT_RIFF    = 4'd1;
  localparam logic [3:0] ST_PAST_END    = 4'd2;
  localparam logic [3:0] ST_FMT_SHORT   = 4'd3;
  localparam logic [3:0] ST_NO_SUBFMT   = 4'd4;
  localparam logic [3:0] ST_DATA_NO_FMT = 4'd5;
  localparam logic [3:0] ST_NO_CHANNELS = 4'd6;
  localparam logic [3:0] ST_WRONG_RATE  = 4'd7;
  localparam logic [3:0] ST_BAD_ENC     = 4'd8;
  localparam logic [3:0] ST_NO_DATA     = 4'd9;

  // APB register indexes
  localparam logic REG_FILE_LENGTH   = 1'b0;
  localparam logic REG_REQUIRED_RATE = 1'b1;

  typedef enum logic [2:0] {
    PH_RIFF,
    PH_HEAD,
    PH_FMT,
    PH_DATA,
    PH_SKIP,
    PH_PAD,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [31:0] sample_bits;
    logic        has_sample;
    logic        finished;
    logic [3:0]  status;
  } result_t;

  // Exact signed 16-bit / 32768 as float32 bits.
  function automatic logic [31:0] pcm_to_float(input logic [15:0] raw);
    logic        sgn;
    logic [15:0] mag;
    logic [3:0]  msb;
    logic [7:0]  expo;
    logic [31:0] shifted;
    sgn = raw[15];
    mag = sgn ? (16'd0 - raw) : raw;
    msb = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (mag[i]) msb = 4'(i);
    end
    if (mag == 16'd0) begin
      pcm_to_float = 32'd0;
    end else begin
      expo    = 8'd112 + {4'd0, msb};
      shifted = {16'd0, mag} << (5'd23 - {1'b0, msb});
      pcm_to_float = {sgn, expo, shifted[22:0]};
    end
  endfunction

endpackage

`default_nettype wire

### rtl/wsfce_parse.sv
// ----------------------------------------------------------------------------
// wsfce_parse
// Parser state and one-byte next-state logic; pushes at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfce_parse (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               restart,
  input  wire logic [31:0]        file_length,
  input  wire logic [31:0]        required_rate,
  input  wire logic               accept,
  input  wire logic [7:0]         file_byte,
  output logic                    push,
  output wsfce_pkg::result_t      res
);

  wsfce_pkg::phase_t phase, phase_next;
  logic [31:0] pos, pos_next;
  logic [31:0] tag, tag_next;
  logic [31:0] csize, csize_next;
  logic [31:0] offset, offset_next;
  logic [15:0] enc, enc_next;
  logic [15:0] chans, chans_next;
  logic [31:0] rate, rate_next;
  logic [15:0] bits, bits_next;
  logic        seen, seen_next;
  logic [31:0] asm_w, asm_next;
  logic [31:0] fstart, fstart_next;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      phase  <= wsfce_pkg::PH_RIFF;
      pos    <= '0;
      tag    <= '0;
      csize  <= '0;
      offset <= '0;
      enc    <= '0;
      chans  <= '0;
      rate   <= '0;
      bits   <= '0;
      seen   <= 1'b0;
      asm_w  <= '0;
      fstart <= '0;
    end else if (accept) begin
      phase  <= phase_next;
      pos    <= pos_next;
      tag    <= tag_next;
      csize  <= csize_next;
      offset <= offset_next;
      enc    <= enc_next;
      chans  <= chans_next;
      rate   <= rate_next;
      bits   <= bits_next;
      seen   <= seen_next;
      asm_w  <= asm_next;
      fstart <= fstart_next;
    end
  end

  logic [4:0]  sh;
  logic [2:0]  h;
  logic [31:0] o_inc;
  logic [32:0] bnd_end;
  logic [31:0] rel;
  logic [2:0]  sb;
  logic [17:0] fb;
  logic        is16;

  always_comb begin
    phase_next  = phase;
    pos_next    = pos;
    tag_next    = tag;
    csize_next  = csize;
    offset_next = offset;
    enc_next    = enc;
    chans_next  = chans;
    rate_next   = rate;
    bits_next   = bits;
    seen_next   = seen;
    asm_next    = asm_w;
    fstart_next = fstart;
    push        = 1'b0;
    res         = '0;
    sh          = '0;
    h           = offset[2:0];
    o_inc       = offset + 32'd1;
    bnd_end     = {1'b0, pos_next} + 33'd8;
    is16        = (bits == 16'd16);
    sb          = is16 ? 3'd2 : 3'd4;
    fb          = is16 ? {1'b0, chans, 1'b0} : {chans, 2'b00};
    rel         = offset - fstart;

    if (phase != wsfce_pkg::PH_DONE && pos < file_length) begin
      pos_next = pos + 32'd1;
      bnd_end  = {1'b0, pos_next} + 33'd8;
      unique case (phase)
        wsfce_pkg::PH_RIFF: begin
          sh = {pos[1:0], 3'b000};
          asm_next = (pos[1:0] == 2'd0) ? {24'd0, file_byte}
                                        : (asm_w | ({24'd0, file_byte} << sh));
          if (pos == 32'd0 && file_length < 32'd12) begin
            push = 1'b1; res.finished = 1'b1; res.status = wsfce_pkg::ST_NOT_RIFF;
          end else if (pos_next == 32'd4 && asm_next != wsfce_pkg::TAG_RIFF) begin
            push = 1'b1; res.finished = 1'b1; res.status = wsfce_pkg::ST_NOT_RIFF;
          end else if (pos_next == 32'd12) begin
            if (asm_next != wsfce_pkg::TAG_WAVE) begin
              push = 1'b1; res.finished = 1'b1; res.status = wsfce_pkg::ST_NOT_RIFF;
            end else if (bnd_end > {1'b0, file_length}) begin
              push = 1'b1; res.finished = 1'b1; res.status = wsfce_pkg::ST_NO_DATA;
            end else begin
              phase_next = wsfce_pkg::PH_HEAD;
              offset_next = '0;
            end
          end
        end
        wsfce_pkg::PH_HEAD: begin
          sh = {h[1:0], 3'b000};
          if (!h[2]) begin
            tag_next = (h == 3'd0) ? {24'd0, file_byte} : (tag | ({24'd0, file_byte} << sh));
          end else begin
            csize_next = (h == 3'd4) ? {24'd0, file_byte}
                                     : (csize | ({24'd0, file_byte} << sh));
          end
          offset_next = {29'd0, h} + 32'd1;
          if (h == 3'd7) begin
            offset_next = '0;
            // header complete: validate against the remaining length
            if (csize_next > file_length - pos_next) begin
              push = 1'b1; res.finished = 1'b1; res.status = wsfce_pkg::ST_PAST_END;
            end else if (tag_next == wsfce_pkg::TAG_FMT) begin
              if (csize_next < 32'd16) begin
                push = 1'b1; res.finished = 1'b1; res.status = wsfce_pkg::ST_FMT_SHORT;
              end else begin
                seen_next  = 1'b1;
                phase_next = wsfce_pkg::PH_FMT;
              end
            end else if (tag_next == wsfce_pkg::TAG_DATA) begin
              if (!seen) begin
                push = 1'b1; res.finished = 1'b1; res.status = wsfce_pkg::ST_DATA_NO_FMT;
              end else if (chans == 16'd0) begin
                push = 1'b1; res.finished = 1'b1; res.status = wsfce_pkg::ST_NO_CHANNELS;
              end else if (rate != required_rate) begin
                push = 1'b1; res.finished = 1'b1; res.status = wsfce_pkg::ST_WRONG_RATE;
              end else if (!((enc == wsfce_pkg::ENC_PCM && bits == 16'd16) ||
                             (enc == wsfce_pkg::ENC_FLOAT && bits == 16'd32))) begin
                push = 1'b1; res.finished = 1'b1; res.status = wsfce_pkg::ST_BAD_ENC;
              end else begin
                fstart_next = '0;
                asm_next    = '0;
                if (csize_next == 32'd0) begin
                  push = 1'b1; res.finished = 1'b1; res.status = wsfce_pkg::ST_OK;
                end else begin
                  phase_next = wsfce_pkg::PH_DATA;
                end
              end
            end else if (csize_next == 32'd0) begin
              if (bnd_end > {1'b0, file_length}) begin
                push = 1'b1; res.finished = 1'b1; res.status = wsfce_pkg::ST_NO_DATA;
              end else begin
                phase_next = wsfce_pkg::PH_HEAD;
              end
            end else begin
              phase_next = wsfce_pkg::PH_SKIP;
            end
          end
        end
        wsfce_pkg::PH_FMT: begin
          offset_next = o_inc;
          if (offset == 32'd0)      enc_next = {enc[15:8], file_byte};
          else if (offset == 32'd1) enc_next = {file_byte, enc[7:0]};
          else if (offset == 32'd2) chans_next = {chans[15:8], file_byte};
          else if (offset == 32'd3) chans_next = {file_byte, chans[7:0]};
          else if (offset == 32'd4) rate_next = {rate[31:8], file_byte};
          else if (offset == 32'd5) rate_next = {rate[31:16], file_byte, rate[7:0]};
          else if (offset == 32'd6) rate_next = {rate[31:24], file_byte, rate[15:0]};
          else if (offset == 32'd7) rate_next = {file_byte, rate[23:0]};
          else if (offset == 32'd14) bits_next = {bits[15:8], file_byte};
          else if (offset == 32'd15) bits_next = {file_byte, bits[7:0]};
          else if (offset == 32'd24) asm_next = {24'd0, file_byte};
          else if (offset == 32'd25 && enc == wsfce_pkg::ENC_EXTENSIBLE)
            enc_next = {file_byte, asm_w[7:0]};
          bnd_end = {1'b0, pos_next} + {32'd0, csize[0]} + 33'd8;
          if (offset == 32'd1 && enc_next == wsfce_pkg::ENC_EXTENSIBLE &&
              csize < 32'd26) begin
            push = 1'b1; res.finished = 1'b1; res.status = wsfce_pkg::ST_NO_SUBFMT;
          end else if (o_inc == csize) begin
            if (bnd_end > {1'b0, file_length}) begin
              push = 1'b1; res.finished = 1'b1; res.status = wsfce_pkg::ST_NO_DATA;
            end else begin
              phase_next  = csize[0] ? wsfce_pkg::PH_PAD : wsfce_pkg::PH_HEAD;
              offset_next = '0;
            end
          end
        end
        wsfce_pkg::PH_DATA: begin
          offset_next = o_inc;
          if (rel < {29'd0, sb}) begin
            sh = {rel[1:0], 3'b000};
            asm_next = (rel == 32'd0) ? {24'd0, file_byte}
                                      : (asm_w | ({24'd0, file_byte} << sh));
            if (rel == {29'd0, sb - 3'd1} &&
                ({1'b0, fstart} + {15'd0, fb}) <= {1'b0, csize}) begin
              res.has_sample  = 1'b1;
              res.sample_bits = is16 ? wsfce_pkg::pcm_to_float(asm_next[15:0]) : asm_next;
            end
          end
          if (({1'b0, rel} + 33'd1) == {15'd0, fb}) fstart_next = o_inc;
          if (o_inc == csize) begin
            push = 1'b1; res.finished = 1'b1; res.status = wsfce_pkg::ST_OK;
          end else if (res.has_sample) begin
            push = 1'b1;
          end
        end
        wsfce_pkg::PH_SKIP: begin
          offset_next = o_inc;
          bnd_end = {1'b0, pos_next} + {32'd0, csize[0]} + 33'd8;
          if (o_inc == csize) begin
            if (bnd_end > {1'b0, file_length}) begin
              push = 1'b1; res.finished = 1'b1; res.status = wsfce_pkg::ST_NO_DATA;
            end else begin
              phase_next  = csize[0] ? wsfce_pkg::PH_PAD : wsfce_pkg::PH_HEAD;
              offset_next = '0;
            end
          end
        end
        wsfce_pkg::PH_PAD: begin
          phase_next  = wsfce_pkg::PH_HEAD;
          offset_next = '0;
        end
        default: begin
          phase_next = wsfce_pkg::PH_DONE;
        end
      endcase
      if (res.finished) phase_next = wsfce_pkg::PH_DONE;
    end
  end

endmodule

`default_nettype wire

### rtl/wsfce_obuf.sv
// ----------------------------------------------------------------------------
// wsfce_obuf
// Two-word result queue; head word drives the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfce_obuf (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire wsfce_pkg::result_t push_word,
  output logic                    full,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output wsfce_pkg::result_t      head
);

  wsfce_pkg::result_t ent1;
  logic [1:0] count;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        head <= ent1;
        if (push) ent1 <= push_word;
      end else if (push) begin
        head <= push_word;
      end
    end else if (push) begin
      if (count == 2'd0) head <= push_word;
      else ent1 <= push_word;
    end
  end

endmodule

`default_nettype wire

### rtl/wav_stream_first_channel_extractor.sv
// ----------------------------------------------------------------------------
// wav_stream_first_channel_extractor
// Parses a RIFF/WAVE byte stream and emits first-channel samples as float32.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  input    | in_valid / in_stall    | file_byte
//  output   | out_valid / out_stall  | sample_bits, has_sample, finished, status
//  config   | APB psel/penable/...   | file_length (0x0), required_rate (0x4)
//
// One byte per cycle while in_stall is low: each accepted byte updates the
// parser registers and may push one result word into a two-entry output queue.
// in_stall rises only when both queue entries hold words not yet taken.
// Synchronous reset clears parser state and the queue; required_rate resets
// to 16000 and file_length to zero. Writing file_length restarts parsing.
// Bytes after the final result, or beyond file_length, are taken and dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_stream_first_channel_extractor (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  file_byte,
  // result output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      sample_bits,
  output logic             has_sample,
  output logic             finished,
  output logic [3:0]       status,
  // APB configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [31:0] file_length;
  logic [31:0] required_rate;
  logic        wr_en;
  logic        restart;
  logic        full;
  logic        accept;
  logic        push;
  wsfce_pkg::result_t res;
  wsfce_pkg::result_t head;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign restart = wr_en && (paddr[2] == wsfce_pkg::REG_FILE_LENGTH);
  assign prdata  = (paddr[2] == wsfce_pkg::REG_FILE_LENGTH) ? file_length : required_rate;

  // hold config registers; write file_length restarts the parser
  always_ff @(posedge clk) begin
    if (rst) begin
      file_length   <= '0;
      required_rate <= wsfce_pkg::RATE_RESET;
    end else if (wr_en) begin
      if (paddr[2] == wsfce_pkg::REG_FILE_LENGTH) file_length <= pwdata;
      else required_rate <= pwdata;
    end
  end

  assign in_stall = full;
  assign accept   = in_valid && !full;

  wsfce_parse u_parse (
    .clk           (clk),
    .rst           (rst),
    .restart       (restart),
    .file_length   (file_length),
    .required_rate (required_rate),
    .accept        (accept),
    .file_byte     (file_byte),
    .push          (push),
    .res           (res)
  );

  wsfce_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push && accept),
    .push_word (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign sample_bits = head.sample_bits;
  assign has_sample  = head.has_sample;
  assign finished    = head.finished;
  assign status      = head.status;

endmodule

`default_nettype wire
